[rtl/wrsf_pkg.sv]
// ----------------------------------------------------------------------------
// wrsf_pkg
// Shared constants, codes and controller/datapath interface types for the
// word removal stream filter.
// ----------------------------------------------------------------------------
package wrsf_pkg;

  localparam int TARGET_MAX   = 8;
  localparam int CHAR_W       = 8;
  localparam int WORD_W       = TARGET_MAX * CHAR_W;
  localparam int LEN_W        = 4;
  localparam int CFG_INDEX_W  = 2;
  localparam int BYTE_SEL_W   = $clog2(TARGET_MAX);

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // configuration register indexes
  localparam cfg_index_t CFG_TARGET_WORD   = 2'd0;
  localparam cfg_index_t CFG_TARGET_LENGTH = 2'd1;
  localparam cfg_index_t CFG_DELIMITER     = 2'd2;

  localparam logic [CHAR_W-1:0] DELIMITER_RESET = 8'd32;

  // source of the next result
  typedef enum logic [1:0] {
    SEL_DELIM,
    SEL_BYTE,
    SEL_CHAR,
    SEL_MARK
  } out_sel_t;

  typedef struct packed {
    logic     load;
    logic     emit;
    out_sel_t sel;
  } wrsf_cmd_t;

  typedef struct packed {
    logic dec_delim;
    logic dec_bytes;
    logic dec_char;
    logic dec_mark;
    logic q_bytes;
    logic q_char;
    logic q_mark;
    logic bytes_done;
    logic out_free;
  } wrsf_status_t;

endpackage

[rtl/word_removal_stream_filter_core.sv]
// ----------------------------------------------------------------------------
// word_removal_stream_filter_core
// Byte-stream word filter that drops every word equal to a configured target.
// ----------------------------------------------------------------------------
// One input transaction is taken and then the block emits its results at
// one per cycle, while the output is not stalled, through a single output
// register; the input stays stalled until the last result is issued. An
// item has 0 to 11 results (optional separator, up to eight replayed prefix
// bytes, the byte itself and the end-of-string marker); an item that only
// extends a matching prefix has none, an ordinary word byte one. Output
// stall holds the sequencer on the pending result. The configuration port
// is always ready and must only be written while no transaction is in flight.
module word_removal_stream_filter_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [wrsf_pkg::CHAR_W-1:0] in_char,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wrsf_pkg::CHAR_W-1:0] out_char,
  output logic                        out_marker,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  wrsf_pkg::cfg_index_t        cfg_index,
  input  logic [wrsf_pkg::WORD_W-1:0] cfg_data
);

  wrsf_pkg::wrsf_cmd_t    cmd;
  wrsf_pkg::wrsf_status_t sts;

  wrsf_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  wrsf_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_char    (in_char),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .out_marker (out_marker),
    .out_last   (out_last),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

[rtl/wrsf_datapath.sv]
// ----------------------------------------------------------------------------
// wrsf_datapath
// Configuration registers, word tracking state, per-transaction result plan,
// replay counter and output register.
// ----------------------------------------------------------------------------
module wrsf_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  wrsf_pkg::cfg_index_t           cfg_index,
  input  logic [wrsf_pkg::WORD_W-1:0]    cfg_data,
  input  logic [wrsf_pkg::CHAR_W-1:0]    in_char,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wrsf_pkg::CHAR_W-1:0]    out_char,
  output logic                           out_marker,
  output logic                           out_last,
  input  wrsf_pkg::wrsf_cmd_t            cmd,
  output wrsf_pkg::wrsf_status_t         sts
);

  logic [wrsf_pkg::WORD_W-1:0] target_word;
  logic [wrsf_pkg::LEN_W-1:0]  target_length;
  logic [wrsf_pkg::CHAR_W-1:0] delimiter;

  logic                        in_word;
  logic                        word_passing;
  logic [wrsf_pkg::LEN_W-1:0]  held_count;
  logic                        emitted_any;

  logic [wrsf_pkg::CHAR_W-1:0] q_char_in;
  logic [wrsf_pkg::LEN_W-1:0]  q_count;
  logic                        q_bytes;
  logic                        q_char;
  logic                        q_mark;
  logic [wrsf_pkg::LEN_W-1:0]  idx;

  // decision for the item on the input port
  logic [wrsf_pkg::LEN_W-1:0]  eff_len;
  logic                        is_delim;
  logic [wrsf_pkg::LEN_W-1:0]  h0;
  logic [wrsf_pkg::LEN_W-1:0]  h1;
  logic                        p0;
  logic                        match;
  logic                        rep;
  logic                        emit_c;
  logic [wrsf_pkg::LEN_W-1:0]  rcount;
  logic                        in_word_next;
  logic                        word_passing_next;
  logic [wrsf_pkg::LEN_W-1:0]  held_count_next;
  logic                        emitted_any_next;
  logic                        out_valid_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    eff_len  = (target_length > wrsf_pkg::LEN_W'(wrsf_pkg::TARGET_MAX))
               ? wrsf_pkg::LEN_W'(wrsf_pkg::TARGET_MAX) : target_length;
    is_delim = (in_char == delimiter);
    h0       = in_word ? held_count : '0;
    p0       = in_word & word_passing;
    h1       = h0 + wrsf_pkg::LEN_W'(1);
    match    = (h0 < eff_len) &&
               (in_char == target_word[h0[wrsf_pkg::BYTE_SEL_W-1:0]*wrsf_pkg::CHAR_W
                                       +: wrsf_pkg::CHAR_W]);
    rep               = 1'b0;
    emit_c            = 1'b0;
    rcount            = h0;
    in_word_next      = 1'b0;
    word_passing_next = 1'b0;
    held_count_next   = '0;
    priority if (is_delim) begin
      // a word equal to the target is dropped, anything else still held is replayed
      rep    = in_word && !word_passing && !((eff_len != '0) && (held_count == eff_len));
      rcount = held_count;
    end else if (p0) begin
      emit_c            = 1'b1;
      in_word_next      = 1'b1;
      word_passing_next = 1'b1;
    end else if (match) begin
      in_word_next    = 1'b1;
      held_count_next = h1;
      rcount          = h1;
      rep             = in_last && (h1 != eff_len);
    end else begin
      rep               = 1'b1;
      emit_c            = 1'b1;
      in_word_next      = 1'b1;
      word_passing_next = 1'b1;
    end
    if (in_last) begin
      in_word_next      = 1'b0;
      word_passing_next = 1'b0;
      held_count_next   = '0;
    end
    emitted_any_next = in_last ? 1'b0 : (emitted_any | rep);
  end

  always_comb begin
    sts.dec_delim  = rep && emitted_any;
    sts.dec_bytes  = rep && (rcount != '0);
    sts.dec_char   = emit_c;
    sts.dec_mark   = in_last;
    sts.q_bytes    = q_bytes;
    sts.q_char     = q_char;
    sts.q_mark     = q_mark;
    sts.bytes_done = ((idx + wrsf_pkg::LEN_W'(1)) == q_count);
    sts.out_free   = !out_valid || !out_stall;
    out_valid_next = cmd.emit ? 1'b1 : (out_stall ? out_valid : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_word   <= '0;
      target_length <= '0;
      delimiter     <= wrsf_pkg::DELIMITER_RESET;
      in_word       <= 1'b0;
      word_passing  <= 1'b0;
      held_count    <= '0;
      emitted_any   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          wrsf_pkg::CFG_TARGET_WORD:   target_word   <= cfg_data;
          wrsf_pkg::CFG_TARGET_LENGTH: target_length <= cfg_data[wrsf_pkg::LEN_W-1:0];
          wrsf_pkg::CFG_DELIMITER:     delimiter     <= cfg_data[wrsf_pkg::CHAR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        in_word      <= in_word_next;
        word_passing <= word_passing_next;
        held_count   <= held_count_next;
        emitted_any  <= emitted_any_next;
      end
      out_valid <= out_valid_next;
    end
  end

  // result plan and output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_char_in <= in_char;
      q_count   <= rcount;
      q_bytes   <= rep && (rcount != '0);
      q_char    <= emit_c;
      q_mark    <= in_last;
      idx       <= '0;
    end else if (cmd.emit && (cmd.sel == wrsf_pkg::SEL_BYTE)) begin
      idx <= idx + wrsf_pkg::LEN_W'(1);
    end
    if (cmd.emit) begin
      unique case (cmd.sel)
        wrsf_pkg::SEL_DELIM: begin
          out_char   <= delimiter;
          out_marker <= 1'b0;
          out_last   <= 1'b0;
        end
        wrsf_pkg::SEL_BYTE: begin
          out_char   <= target_word[idx[wrsf_pkg::BYTE_SEL_W-1:0]*wrsf_pkg::CHAR_W
                                    +: wrsf_pkg::CHAR_W];
          out_marker <= 1'b0;
          out_last   <= 1'b0;
        end
        wrsf_pkg::SEL_CHAR: begin
          out_char   <= q_char_in;
          out_marker <= 1'b0;
          out_last   <= 1'b0;
        end
        wrsf_pkg::SEL_MARK: begin
          out_char   <= '0;
          out_marker <= 1'b1;
          out_last   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result written over a waiting result");

  a_held_bounded: assert property (@(posedge clk) disable iff (rst)
    held_count <= wrsf_pkg::LEN_W'(wrsf_pkg::TARGET_MAX))
    else $error("held count beyond target capacity");

  a_passing_in_word: assert property (@(posedge clk) disable iff (rst)
    word_passing |-> in_word)
    else $error("streaming flag set outside a word");

  a_marker_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && in_last) |=> (!in_word && !emitted_any && (held_count == '0)))
    else $error("word state not cleared at end of string");

  a_replay_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && (cmd.sel == wrsf_pkg::SEL_BYTE)) |-> (idx < q_count))
    else $error("replay ran past the held count");

endmodule

[rtl/wrsf_controller.sv]
// ----------------------------------------------------------------------------
// wrsf_controller
// Sequencer that takes one input transaction and then issues its results in
// order: separator, replayed prefix bytes, current byte, end marker.
// ----------------------------------------------------------------------------
module wrsf_controller (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  wrsf_pkg::wrsf_status_t sts,
  output wrsf_pkg::wrsf_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    SEND_DELIM,
    SEND_BYTE,
    SEND_CHAR,
    SEND_MARK
  } state_t;

  state_t state;
  state_t state_next;

  function automatic state_t pick(input logic d, input logic b, input logic c,
                                  input logic m);
    state_t s;
    priority if (d) s = SEND_DELIM;
    else if (b)     s = SEND_BYTE;
    else if (c)     s = SEND_CHAR;
    else if (m)     s = SEND_MARK;
    else            s = IDLE;
    return s;
  endfunction

  assign in_stall = (state != IDLE);

  always_comb begin
    cmd.load   = 1'b0;
    cmd.emit   = 1'b0;
    cmd.sel    = wrsf_pkg::SEL_CHAR;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = pick(sts.dec_delim, sts.dec_bytes, sts.dec_char, sts.dec_mark);
        end
      end
      SEND_DELIM: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = wrsf_pkg::SEL_DELIM;
          state_next = pick(1'b0, sts.q_bytes, sts.q_char, sts.q_mark);
        end
      end
      SEND_BYTE: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = wrsf_pkg::SEL_BYTE;
          if (sts.bytes_done) begin
            state_next = pick(1'b0, 1'b0, sts.q_char, sts.q_mark);
          end
        end
      end
      SEND_CHAR: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = wrsf_pkg::SEL_CHAR;
          state_next = pick(1'b0, 1'b0, 1'b0, sts.q_mark);
        end
      end
      SEND_MARK: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = wrsf_pkg::SEL_MARK;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == IDLE) && !cmd.emit)
    else $error("transaction taken while results pending");

  a_mark_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && (cmd.sel == wrsf_pkg::SEL_MARK)) |=> (state == IDLE))
    else $error("sequencer did not finish after end marker");

  a_stall_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> in_stall && !cmd.load)
    else $error("input open while results pending");

endmodule

[verif/tb_word_removal_stream_filter_core.sv]
// ----------------------------------------------------------------------------
// tb_word_removal_stream_filter_core
// Self-checking bench for the word removal stream filter. Text bytes are
// pushed through the input channel under several target, length and
// delimiter settings. A small predictor works out the filtered text and
// every output transaction is checked against it in order. Idle gaps,
// random output stalls and one long output hold-off shake the handshakes.
// ----------------------------------------------------------------------------
module tb_word_removal_stream_filter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASE_ITEMS   = 20;
  localparam int unsigned MAX_REPORTS   = 10;

  // no register behind this index, writes must be ignored
  localparam wrsf_pkg::cfg_index_t CFG_UNUSED = 2'd3;

  localparam logic [wrsf_pkg::WORD_W-1:0] WORD_LAPTOP = 64'h0000_706F_7470_614C;
  localparam logic [wrsf_pkg::CHAR_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [wrsf_pkg::CHAR_W-1:0] CH_COMMA    = 8'h2C;

  typedef struct packed {
    logic [wrsf_pkg::CHAR_W-1:0] ch;
    logic                        marker;
    logic                        last;
  } text_out_t;

  typedef enum int {
    WK_EXACT,
    WK_PREFIX,
    WK_DIVERGE,
    WK_LONGER,
    WK_RANDOM
  } word_kind_t;

  class filtered_text_model;
    logic [wrsf_pkg::WORD_W-1:0] word_reg;
    logic [wrsf_pkg::LEN_W-1:0]  len_reg;
    logic [wrsf_pkg::CHAR_W-1:0] delim;
    bit                          in_word;
    bit                          passing;
    bit                          emitted_any;
    int unsigned                 held;
    text_out_t                   expected_q[$];
    int unsigned                 mismatches;
    int unsigned                 results_seen;
    int unsigned                 inputs_seen;

    function new();
      word_reg     = '0;
      len_reg      = '0;
      delim        = wrsf_pkg::DELIMITER_RESET;
      in_word      = 1'b0;
      passing      = 1'b0;
      emitted_any  = 1'b0;
      held         = 0;
      mismatches   = 0;
      results_seen = 0;
      inputs_seen  = 0;
    endfunction

    function int unsigned eff_len();
      return (len_reg > wrsf_pkg::TARGET_MAX) ? wrsf_pkg::TARGET_MAX : int'(len_reg);
    endfunction

    function logic [wrsf_pkg::CHAR_W-1:0] tgt_byte(int unsigned i);
      return word_reg[(i % wrsf_pkg::TARGET_MAX) * wrsf_pkg::CHAR_W +: wrsf_pkg::CHAR_W];
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void push_out(logic [wrsf_pkg::CHAR_W-1:0] ch, logic marker, logic last);
      text_out_t r;
      r.ch       = ch;
      r.marker   = marker;
      r.last     = last;
      expected_q = {expected_q, r};
    endfunction

    // the word is kept: a separator first if a word was kept before it in the string, then the held prefix
    function void replay();
      if (emitted_any) push_out(delim, 1'b0, 1'b0);
      for (int unsigned i = 0; i < held && i < wrsf_pkg::TARGET_MAX; i++)
        push_out(tgt_byte(i), 1'b0, 1'b0);
      emitted_any = 1'b1;
      held        = 0;
    endfunction

    function void close_word();
      if (in_word && !passing) begin
        if (!(eff_len() != 0 && held == eff_len())) replay();
      end
      in_word = 1'b0;
      passing = 1'b0;
      held    = 0;
    endfunction

    function void write_reg(wrsf_pkg::cfg_index_t idx, logic [wrsf_pkg::WORD_W-1:0] data);
      case (idx)
        wrsf_pkg::CFG_TARGET_WORD:   word_reg = data;
        wrsf_pkg::CFG_TARGET_LENGTH: len_reg  = data[wrsf_pkg::LEN_W-1:0];
        wrsf_pkg::CFG_DELIMITER:     delim    = data[wrsf_pkg::CHAR_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_byte(logic [wrsf_pkg::CHAR_W-1:0] ch, logic last);
      inputs_seen++;
      if (ch == delim) begin
        close_word();
      end else begin
        if (!in_word) begin
          in_word = 1'b1;
          passing = 1'b0;
          held    = 0;
        end
        if (passing) begin
          push_out(ch, 1'b0, 1'b0);
        end else if (held < eff_len() && ch == tgt_byte(held)) begin
          held++;
        end else begin
          replay();
          push_out(ch, 1'b0, 1'b0);
          passing = 1'b1;
        end
      end
      if (last) begin
        close_word();
        push_out('0, 1'b1, 1'b1);
        emitted_any = 1'b0;
      end
    endfunction

    function void check_output(logic [wrsf_pkg::CHAR_W-1:0] ch, logic marker, logic last);
      text_out_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d unexpected: char %02h marker %0b last %0b",
                   results_seen, ch, marker, last);
        return;
      end
      want = expected_q.pop_front();
      if (want.ch !== ch || want.marker !== marker || want.last !== last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d: expected char %02h marker %0b last %0b, got %02h %0b %0b",
                   results_seen, want.ch, want.marker, want.last, ch, marker, last);
      end
    endfunction
  endclass

  logic                        clk        = 1'b0;
  logic                        rst        = 1'b1;
  logic                        in_valid   = 1'b0;
  logic                        in_stall;
  logic [wrsf_pkg::CHAR_W-1:0] in_char    = '0;
  logic                        in_last    = 1'b0;
  logic                        out_valid;
  logic                        out_stall  = 1'b0;
  logic [wrsf_pkg::CHAR_W-1:0] out_char;
  logic                        out_marker;
  logic                        out_last;
  logic                        cfg_valid  = 1'b0;
  logic                        cfg_ready;
  wrsf_pkg::cfg_index_t        cfg_index  = wrsf_pkg::CFG_TARGET_WORD;
  logic [wrsf_pkg::WORD_W-1:0] cfg_data   = '0;

  logic              out_hold      = 1'b0;
  int unsigned       in_idle_pct   = 0;
  int unsigned       out_stall_pct = 0;
  int unsigned       items_sent    = 0;
  int unsigned       settings_run  = 0;
  int unsigned       cycle_count   = 0;

  filtered_text_model board;

  word_removal_stream_filter_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char    (in_char),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .out_marker (out_marker),
    .out_last   (out_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6ns clk = 1'b1;
    #6ns clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_word_removal_stream_filter_core failed");
      $finish;
    end
  end

  // output side: check each transaction, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_output(out_char, out_marker, out_last);
    out_stall <= out_hold || ($urandom_range(99) < out_stall_pct);
  end

  task automatic hold_output(input int unsigned cycles);
    out_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    out_hold <= 1'b0;
  endtask

  task automatic send_byte(input logic [wrsf_pkg::CHAR_W-1:0] ch, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= ch;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_byte(ch, last);
    items_sent++;
  endtask

  task automatic send_str(input string s, input bit last_at_end);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], last_at_end && (i == s.len() - 1));
  endtask

  // drain the expected text, then give a held-prefix item time to finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input wrsf_pkg::cfg_index_t idx,
                           input logic [wrsf_pkg::WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, data);
  endtask

  task automatic set_target(input logic [wrsf_pkg::WORD_W-1:0] word,
                            input logic [wrsf_pkg::LEN_W-1:0] len,
                            input logic [wrsf_pkg::CHAR_W-1:0] delim);
    logic [wrsf_pkg::WORD_W-1:0] noise;
    wait_idle();
    noise = {$urandom, $urandom};
    write_reg(wrsf_pkg::CFG_TARGET_WORD, word);
    write_reg(wrsf_pkg::CFG_TARGET_LENGTH, {noise[wrsf_pkg::WORD_W-1:wrsf_pkg::LEN_W], len});
    write_reg(wrsf_pkg::CFG_DELIMITER, {noise[wrsf_pkg::WORD_W-1:wrsf_pkg::CHAR_W], delim});
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  function automatic logic [wrsf_pkg::CHAR_W-1:0] any_char();
    logic [wrsf_pkg::CHAR_W-1:0] c;
    c = $urandom_range(1) ? wrsf_pkg::CHAR_W'($urandom_range(8'h7A, 8'h61))
                          : wrsf_pkg::CHAR_W'($urandom_range(255));
    if (c == board.delim) c = c ^ 8'h01;
    return c;
  endfunction

  function automatic void add_gap(ref logic [wrsf_pkg::CHAR_W-1:0] q[$],
                                  input int unsigned n);
    repeat (n) q = {q, board.delim};
  endfunction

  // one string of words built around the target, closed with a last byte
  task automatic send_text(input int unsigned n_words);
    logic [wrsf_pkg::CHAR_W-1:0] text[$];
    int unsigned                 tlen;
    int unsigned                 plen;
    word_kind_t                  kind;
    tlen = board.eff_len();
    text = {};
    if ($urandom_range(3) == 0) add_gap(text, $urandom_range(2, 1));
    for (int unsigned w = 0; w < n_words; w++) begin
      kind = word_kind_t'($urandom_range(4));
      if (tlen == 0) kind = WK_RANDOM;
      case (kind)
        WK_EXACT: begin
          for (int unsigned i = 0; i < tlen; i++) text = {text, board.tgt_byte(i)};
        end
        WK_PREFIX: begin
          plen = $urandom_range(tlen, 1);
          for (int unsigned i = 0; i < plen; i++) text = {text, board.tgt_byte(i)};
        end
        WK_DIVERGE: begin
          plen = $urandom_range(tlen - 1, 0);
          for (int unsigned i = 0; i < plen; i++) text = {text, board.tgt_byte(i)};
          text = {text, board.tgt_byte(plen) ^ wrsf_pkg::CHAR_W'(1 << $urandom_range(7))};
          repeat ($urandom_range(2)) text = {text, any_char()};
        end
        WK_LONGER: begin
          for (int unsigned i = 0; i < tlen; i++) text = {text, board.tgt_byte(i)};
          repeat ($urandom_range(2, 1)) text = {text, any_char()};
        end
        default: begin
          repeat ($urandom_range(6, 1)) text = {text, any_char()};
        end
      endcase
      if (w + 1 < n_words) add_gap(text, $urandom_range(3, 1));
      else if ($urandom_range(2) == 0) add_gap(text, $urandom_range(2, 1));
    end
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic run_phase(input logic [wrsf_pkg::WORD_W-1:0] word,
                           input logic [wrsf_pkg::LEN_W-1:0] len,
                           input logic [wrsf_pkg::CHAR_W-1:0] delim, input int unsigned in_pct,
                           input int unsigned out_pct, input bit hold);
    int unsigned first;
    set_target(word, len, delim);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    if (hold) begin
      fork
        hold_output(HOLD_CYCLES);
      join_none
    end
    first = items_sent;
    while (items_sent - first < PHASE_ITEMS) send_text($urandom_range(4, 1));
    // leave a whole target held open so the next setting lands mid-word
    for (int unsigned i = 0; i < board.eff_len(); i++) send_byte(board.tgt_byte(i), 1'b0);
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: nothing removed, space splits words
    send_str(" a  b", 1'b1);
    set_target(WORD_LAPTOP, 4'd6, CH_SPACE);
    send_str("Laptop Lax Lap ", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    run_phase(WORD_LAPTOP, 4'd6, CH_SPACE, 0, 0, 1'b0);
    run_phase({wrsf_pkg::WORD_W{1'b1}}, 4'd8, 8'h00, 49, 0, 1'b0);
    run_phase({$urandom, $urandom}, 4'd15, 8'hFF, 0, 49, 1'b0);
    run_phase('0, 4'd1, CH_SPACE, 12, 12, 1'b0);
    run_phase(WORD_LAPTOP, 4'd6, CH_SPACE, 0, 0, 1'b1);
    // length shrinks under the six held bytes
    run_phase(WORD_LAPTOP, 4'd2, CH_COMMA, 12, 12, 1'b0);
    run_phase({$urandom, $urandom}, 4'd0, CH_SPACE, 49, 49, 1'b0);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d results from %0d input transactions under %0d settings",
             board.results_seen, board.inputs_seen, settings_run);
    $display("lengths 0 to 15, delimiters 00/20/2c/ff, idle and stall mixes, %0d-cycle hold",
             HOLD_CYCLES);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_word_removal_stream_filter_core passed");
    end else begin
      $display("tb_word_removal_stream_filter_core failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/wrsf_pkg.sv
rtl/wrsf_datapath.sv
rtl/wrsf_controller.sv
rtl/word_removal_stream_filter_core.sv
verif/tb_word_removal_stream_filter_core.sv
